// File: hdl/pft_pkg.sv
// Package for the printf format tokenizer: payload structs, result bundle,
// character and token kind constants, queue sizing. No dependencies.
package pft_pkg;

  // Input word: one format character, with a flag on the last one.
  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
  } in_t;

  // Output word: one token stream result.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic [3:0] token_kind;
    logic       run_last;
  } out_t;

  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);

  // All results caused by one input word.
  typedef struct packed {
    out_t [MAX_RES-1:0]   res;
    logic [RES_CNT_W-1:0] cnt;
  } bundle_t;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_PCT  = 2'd1,
    MODE_SPEC = 2'd2
  } mode_e;

  // Token kinds
  localparam logic [3:0] KIND_LITERAL      = 4'd0;
  localparam logic [3:0] KIND_SIGNED_INT   = 4'd3;
  localparam logic [3:0] KIND_UNSIGNED_INT = 4'd8;
  localparam logic [3:0] KIND_FLOAT        = 4'd11;
  localparam logic [3:0] KIND_CHAR         = 4'd12;
  localparam logic [3:0] KIND_STRING       = 4'd13;
  localparam logic [3:0] KIND_POINTER      = 4'd14;
  localparam logic [3:0] KIND_OTHER        = 4'd15;

  // Characters
  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_H     = "h";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_D     = "d";
  localparam logic [7:0] CH_I     = "i";
  localparam logic [7:0] CH_O     = "o";
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_E     = "e";
  localparam logic [7:0] CH_UE    = "E";
  localparam logic [7:0] CH_F     = "f";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_G     = "g";
  localparam logic [7:0] CH_UG    = "G";
  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_C     = "c";
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_P     = "p";
  localparam logic [7:0] CH_UC    = "C";
  localparam logic [7:0] CH_US    = "S";
  localparam logic [7:0] CH_M     = "m";
  localparam logic [7:0] CH_N     = "n";

endpackage

// File: hdl/printf_format_tokenizer.sv
// Printf format tokenizer top level: front classifier, bundle queue, back serializer.
// Accepts one character per cycle while the 4-deep bundle queue has room.
// A character's results are written into the bundle queue, then registered into the output word.
// Throughput: one result word per cycle at the output while out_stall_i is low;
// a character with several results sends them one after another, bursts absorbed by the queue.
// Reset (rst_ni low, asynchronous) returns parsing to text mode and empties the queue.
module printf_format_tokenizer import pft_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic    push;
  logic    pop;
  logic    q_full;
  logic    head_valid;
  bundle_t push_data;
  bundle_t head;

  pft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  pft_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: hdl/pft_front.sv
// Front end of the format tokenizer: holds parse state and turns each
// accepted character into a bundle of up to four results. Uses pft_pkg.
module pft_front import pft_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  in_t     in_data_i,
  input  logic    q_full_i,
  output logic    in_stall_o,
  output logic    push_o,
  output bundle_t bundle_o
);

  typedef struct packed {
    mode_e      mode;
    logic       text_pending;
    logic [1:0] long_mods;
    logic [1:0] short_mods;
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    bundle_t bun;
  } work_t;

  localparam pstate_t PSTATE_RESET = '{MODE_TEXT, 1'b0, 2'd0, 2'd0};

  function automatic work_t put_res(work_t w, logic [7:0] c, logic cv, logic te,
                                    logic [3:0] kind);
    work_t r;
    r = w;
    if (w.bun.cnt < RES_CNT_W'(MAX_RES)) begin
      r.bun.res[RES_IDX_W'(w.bun.cnt)] = '{c, cv, te, kind, 1'b0};
      r.bun.cnt = w.bun.cnt + RES_CNT_W'(1);
    end
    return r;
  endfunction

  function automatic work_t put_char(work_t w, logic [7:0] c);
    return put_res(w, c, 1'b1, 1'b0, KIND_LITERAL);
  endfunction

  // Fold the end into a preceding character-only result of this word.
  function automatic work_t put_end(work_t w, logic [3:0] kind);
    work_t                r;
    logic [RES_IDX_W-1:0] li;
    r  = w;
    li = RES_IDX_W'(w.bun.cnt - RES_CNT_W'(1));
    if (w.bun.cnt != '0 && w.bun.res[li].char_valid && !w.bun.res[li].token_end) begin
      r.bun.res[li].token_end  = 1'b1;
      r.bun.res[li].token_kind = kind;
    end else begin
      r = put_res(w, 8'd0, 1'b0, 1'b1, kind);
    end
    return r;
  endfunction

  function automatic logic [3:0] conv_kind(logic [7:0] c, logic [1:0] lm, logic [1:0] sm);
    logic [3:0] k;
    case (c)
      CH_D, CH_I:                 k = KIND_SIGNED_INT + {2'b00, sm} - {2'b00, lm};
      CH_O, CH_U, CH_X, CH_UX:    k = KIND_UNSIGNED_INT + {2'b00, sm} - {2'b00, lm};
      CH_E, CH_UE, CH_F, CH_UF,
      CH_G, CH_UG, CH_A, CH_UA:   k = KIND_FLOAT;
      CH_C:                       k = KIND_CHAR;
      CH_S:                       k = KIND_STRING;
      CH_P:                       k = KIND_POINTER;
      CH_UC, CH_US, CH_M, CH_N:   k = KIND_OTHER;
      default:                    k = KIND_LITERAL;
    endcase
    return k;
  endfunction

  function automatic work_t spec_char(work_t w, logic [7:0] c);
    work_t      r;
    logic [3:0] kind;
    r    = w;
    kind = conv_kind(c, w.st.long_mods, w.st.short_mods);
    if (c == CH_SPACE) begin
      r    = put_char(r, c);
      r    = put_end(r, KIND_LITERAL);
      r.st = PSTATE_RESET;
    end else if (c == CH_PCT) begin
      r = put_end(r, KIND_LITERAL);
      r = put_char(r, c);
      r.st.long_mods  = 2'd0;
      r.st.short_mods = 2'd0;
    end else if (c == CH_H) begin
      r = put_char(r, c);
      if (r.st.short_mods < 2'd2) r.st.short_mods = r.st.short_mods + 2'd1;
      r.st.long_mods = 2'd0;
    end else if (c == CH_L) begin
      r = put_char(r, c);
      if (r.st.long_mods < 2'd2) r.st.long_mods = r.st.long_mods + 2'd1;
      r.st.short_mods = 2'd0;
    end else begin
      r = put_char(r, c);
      if (kind != KIND_LITERAL) begin
        r    = put_end(r, kind);
        r.st = PSTATE_RESET;
      end
    end
    return r;
  endfunction

  function automatic work_t step(pstate_t st, logic [7:0] c, logic fin);
    work_t w;
    w.st  = st;
    w.bun = '0;
    case (st.mode)
      MODE_SPEC: begin
        w = spec_char(w, c);
      end
      MODE_PCT: begin
        if (c == CH_PCT) begin
          w = put_char(w, c);
          w.st.text_pending = 1'b1;
          w.st.mode         = MODE_TEXT;
        end else begin
          if (w.st.text_pending) w = put_end(w, KIND_LITERAL);
          w.st.text_pending = 1'b0;
          w = put_char(w, CH_PCT);
          w.st.mode       = MODE_SPEC;
          w.st.long_mods  = 2'd0;
          w.st.short_mods = 2'd0;
          w = spec_char(w, c);
        end
      end
      default: begin
        w.st.mode = MODE_TEXT;
        if (c == CH_PCT) begin
          w.st.mode = MODE_PCT;
        end else begin
          w = put_char(w, c);
          w.st.text_pending = 1'b1;
        end
      end
    endcase
    // End of string: flush leftovers as literals
    if (fin) begin
      if (w.st.mode == MODE_PCT) begin
        if (w.st.text_pending) w = put_end(w, KIND_LITERAL);
        w = put_char(w, CH_PCT);
        w = put_end(w, KIND_LITERAL);
      end else if (w.st.mode == MODE_SPEC || w.st.text_pending) begin
        w = put_end(w, KIND_LITERAL);
      end
      w.st = PSTATE_RESET;
    end
    if (w.bun.cnt != '0) begin
      w.bun.res[RES_IDX_W'(w.bun.cnt - RES_CNT_W'(1))].run_last = 1'b1;
    end
    return w;
  endfunction

  pstate_t st_q, st_d;
  work_t   work;
  logic    accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    work = step(st_q, in_data_i.ch, in_data_i.final_char);
    st_d = accept ? work.st : st_q;
  end

  // Words that produce nothing never enter the queue
  assign bundle_o = work.bun;
  assign push_o   = accept && (work.bun.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PSTATE_RESET;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: hdl/pft_fifo.sv
// Small bundle queue between front and back of the format tokenizer.
// Uses pft_pkg for the bundle type and queue depth.
module pft_fifo import pft_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    head_valid_o,
  output bundle_t head_o
);

  bundle_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + Q_CNT_W'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - Q_CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: hdl/pft_back.sv
// Back end of the format tokenizer: walks the head bundle one result a
// cycle, while the output is not stalled, into a registered output word. Uses pft_pkg.
module pft_back import pft_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  input  bundle_t head_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output out_t    out_data_o
);

  logic [RES_IDX_W-1:0] idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q;
  logic                 load;
  logic                 last;

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last  = (RES_CNT_W'(idx_q) + RES_CNT_W'(1)) == head_i.cnt;
  assign pop_o = load && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? '0 : idx_q + RES_IDX_W'(1);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head_i.res[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/sv/pft_token_scoreboard.sv
// Scoreboard for the printf format tokenizer: predicts the token words
// for each accepted character and checks the words that leave the block.
// Depends on pft_pkg for the word structs, modes, kinds and characters.
package pft_token_scoreboard_pkg;
  import pft_pkg::*;

  class pft_token_scoreboard;
    mode_e       mode;
    bit          text_open;
    logic [1:0]  n_long;
    logic [1:0]  n_short;
    out_t        pending_tokens[$];
    out_t        step_words[$];
    int unsigned errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      mode      = MODE_TEXT;
      text_open = 1'b0;
      n_long    = 2'd0;
      n_short   = 2'd0;
    endfunction

    function void emit_char(logic [7:0] c);
      out_t w;
      w.out_char   = c;
      w.char_valid = 1'b1;
      w.token_end  = 1'b0;
      w.token_kind = KIND_LITERAL;
      w.run_last   = 1'b0;
      if (step_words.size() < MAX_RES) step_words.push_back(w);
    endfunction

    function void close_token(logic [3:0] kind);
      out_t w;
      // Fold the end into a trailing char-only word of this step.
      if (step_words.size() > 0 && step_words[step_words.size()-1].char_valid &&
          !step_words[step_words.size()-1].token_end) begin
        w = step_words.pop_back();
        w.token_end  = 1'b1;
        w.token_kind = kind;
        step_words.push_back(w);
        return;
      end
      w.out_char   = 8'd0;
      w.char_valid = 1'b0;
      w.token_end  = 1'b1;
      w.token_kind = kind;
      w.run_last   = 1'b0;
      if (step_words.size() < MAX_RES) step_words.push_back(w);
    endfunction

    function logic [3:0] conversion_kind(logic [7:0] c);
      int diff;
      diff = int'(n_long) - int'(n_short);
      case (c)
        CH_D, CH_I:                 return 4'(KIND_SIGNED_INT - diff);
        CH_O, CH_U, CH_X, CH_UX:    return 4'(KIND_UNSIGNED_INT - diff);
        CH_E, CH_UE, CH_F, CH_UF,
        CH_G, CH_UG, CH_A, CH_UA:   return KIND_FLOAT;
        CH_C:                       return KIND_CHAR;
        CH_S:                       return KIND_STRING;
        CH_P:                       return KIND_POINTER;
        CH_UC, CH_US, CH_M, CH_N:   return KIND_OTHER;
        default:                    return KIND_LITERAL;
      endcase
    endfunction

    function void spec_char(logic [7:0] c);
      logic [3:0] kind;
      if (c == CH_SPACE) begin
        // A space inside a specifier turns it into literal text.
        emit_char(c);
        close_token(KIND_LITERAL);
        clear_state();
      end else if (c == CH_PCT) begin
        // Close the pending specifier and start a new one.
        close_token(KIND_LITERAL);
        emit_char(c);
        n_long  = 2'd0;
        n_short = 2'd0;
      end else if (c == CH_H) begin
        emit_char(c);
        if (n_short < 2'd2) n_short = n_short + 2'd1;
        n_long = 2'd0;
      end else if (c == CH_L) begin
        emit_char(c);
        if (n_long < 2'd2) n_long = n_long + 2'd1;
        n_short = 2'd0;
      end else begin
        kind = conversion_kind(c);
        emit_char(c);
        if (kind != KIND_LITERAL) begin
          close_token(kind);
          clear_state();
        end
      end
    endfunction

    // Predict the words caused by one accepted character.
    function void tokenize_char(in_t w);
      logic [7:0] c;
      out_t       last_word;
      c = w.ch;
      step_words.delete();
      case (mode)
        MODE_SPEC: spec_char(c);
        MODE_PCT: begin
          if (c == CH_PCT) begin
            emit_char(c);
            text_open = 1'b1;
            mode      = MODE_TEXT;
          end else begin
            if (text_open) close_token(KIND_LITERAL);
            text_open = 1'b0;
            emit_char(CH_PCT);
            mode    = MODE_SPEC;
            n_long  = 2'd0;
            n_short = 2'd0;
            spec_char(c);
          end
        end
        default: begin
          mode = MODE_TEXT;
          if (c == CH_PCT) begin
            mode = MODE_PCT;
          end else begin
            emit_char(c);
            text_open = 1'b1;
          end
        end
      endcase
      if (w.final_char) begin
        // Flush whatever is left as literal tokens.
        if (mode == MODE_PCT) begin
          if (text_open) close_token(KIND_LITERAL);
          emit_char(CH_PCT);
          close_token(KIND_LITERAL);
        end else if (mode == MODE_SPEC) begin
          close_token(KIND_LITERAL);
        end else if (text_open) begin
          close_token(KIND_LITERAL);
        end
        clear_state();
      end
      if (step_words.size() > 0) begin
        last_word = step_words.pop_back();
        last_word.run_last = 1'b1;
        step_words.push_back(last_word);
      end
      foreach (step_words[i]) pending_tokens.push_back(step_words[i]);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
        errors++;
      end
    endfunction

    // Check one word that left the block against the oldest prediction.
    function void check_token_word(out_t got);
      out_t exp_word;
      if (pending_tokens.size() == 0) begin
        $error("unexpected word: out_char 0x%0h token_end %0b", got.out_char, got.token_end);
        errors++;
        return;
      end
      exp_word = pending_tokens.pop_front();
      compare_field("out_char", exp_word.out_char, got.out_char);
      compare_field("char_valid", exp_word.char_valid, got.char_valid);
      compare_field("token_end", exp_word.token_end, got.token_end);
      compare_field("token_kind", exp_word.token_kind, got.token_kind);
      compare_field("run_last", exp_word.run_last, got.run_last);
    endfunction
  endclass

endpackage

// File: tb/sv/printf_format_tokenizer_tb.sv
// Top-level testbench for printf_format_tokenizer: drives format strings,
// directed then random, under varying back pressure and checks every word.
// Depends on pft_pkg and pft_token_scoreboard_pkg.
module printf_format_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pft_pkg::*;
  import pft_token_scoreboard_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 60;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  pft_token_scoreboard sb;

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 62;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned words_sent    = 0;

  string      fill_chars = "0123456789.-+#*";
  logic [7:0] conv_letters [21] = '{CH_D, CH_I, CH_O, CH_U, CH_X, CH_UX, CH_E, CH_UE,
                                    CH_F, CH_UF, CH_G, CH_UG, CH_A, CH_UA, CH_C, CH_S,
                                    CH_P, CH_UC, CH_US, CH_M, CH_N};

  printf_format_tokenizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Output stall: random, or held for a requested stretch.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Check outputs and watch for a stuck run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_token_word(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Entered and left at a falling edge; valid stays high for back-to-back words.
  task automatic send_word(input in_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.tokenize_char(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input string s);
    in_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.ch         = s[i];
      w.final_char = (i == s.len() - 1);
      send_word(w);
    end
  endtask

  // Leave at a fresh falling edge so the next driver owns that step.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_tokens.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_phase(input int unsigned send_pct, input int unsigned recv_pct);
    wait_drained();
    @(posedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk_i);
  endtask

  task automatic request_hold(input int unsigned cycles);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    hold_req = cycles;
    @(negedge clk_i);
  endtask

  task automatic push_mods(ref logic [7:0] fmt[$], input int unsigned max_mods);
    repeat ($urandom_range(0, max_mods)) fmt.push_back($urandom_range(0, 1) ? CH_H : CH_L);
  endtask

  // Build one format string, mostly well-formed, and send it.
  task automatic send_random_format();
    logic [7:0]  fmt[$];
    logic [7:0]  c;
    int unsigned parts;
    int unsigned pick;
    in_t         w;
    parts = $urandom_range(1, 5);
    for (int p = 0; p < parts; p++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        repeat ($urandom_range(1, 4)) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_PCT);
          fmt.push_back(c);
        end
      end else if (pick < 40) begin
        fmt.push_back(CH_PCT);
        fmt.push_back(CH_PCT);
      end else if (pick < 85) begin
        fmt.push_back(CH_PCT);
        repeat ($urandom_range(0, 2))
          fmt.push_back(fill_chars[$urandom_range(0, fill_chars.len() - 1)]);
        push_mods(fmt, 3);
        fmt.push_back(conv_letters[$urandom_range(0, 20)]);
      end else if (pick < 93) begin
        // Break the specifier with a space or a new percent.
        fmt.push_back(CH_PCT);
        push_mods(fmt, 2);
        fmt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_PCT);
      end else begin
        repeat ($urandom_range(1, 3)) fmt.push_back(8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) fmt.push_back(CH_PCT);
    foreach (fmt[i]) begin
      w.ch         = fmt[i];
      w.final_char = (i == fmt.size() - 1);
      send_word(w);
    end
  endtask

  task automatic send_random_until(input int unsigned total);
    while (words_sent < total) send_random_format();
  endtask

  initial begin
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: character extremes, typed conversions, escapes, broken specifiers.
    send_word(in_t'{ch: 8'd1, final_char: 1'b0});
    send_word(in_t'{ch: 8'd255, final_char: 1'b1});
    send_string("%lld");
    send_string("%hhu");
    send_string("a%%");
    send_string("%l %");
    send_string("%h%s");
    send_string("%5");

    send_random_until(110);
    request_hold(HOLD_CYCLES);
    send_random_until(200);
    wait_drained();
    send_random_until(220);

    set_phase(62, 37);
    send_random_until(370);

    set_phase(0, 0);
    send_random_until(440);
    request_hold(HOLD_CYCLES);
    send_random_until(530);

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/pft_pkg.sv
hdl/pft_front.sv
hdl/pft_fifo.sv
hdl/pft_back.sv
hdl/printf_format_tokenizer.sv
tb/sv/pft_token_scoreboard.sv
tb/sv/printf_format_tokenizer_tb.sv
